### sv/bbi_pkg.sv
// Shared types and constants of the 3x3 interleaved box blur.
// No dependencies; imported by every other file of the block.
package bbi_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int CFG_W   = 13;
  localparam int SUM_W   = 12;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_LINE_BYTES = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT  = 1'b1;

  localparam logic [CFG_W-1:0] LINE_BYTES_RST = 13'd1920;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 13'd480;
  localparam logic [CFG_W-1:0] MAX_ROWS       = 13'd4096;

  // sum / 9 == (sum * 7282) >> 16 for every sum of nine bytes
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W = SUM_W + RECIP_W;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef struct packed {
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } meta_t;

  typedef struct packed {
    logic [PIX_W-1:0]   mean;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] column;
  } result_t;

endpackage

### sv/bbi_if.sv
// Stream interfaces of the box blur: byte input and result output.
// Depends on bbi_pkg.
interface bbi_in_if import bbi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_byte;
  logic             frame_start;

  modport source (output valid, pixel_byte, frame_start, input ready);
  modport sink   (input valid, pixel_byte, frame_start, output ready);
endinterface

interface bbi_out_if import bbi_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   mean_value;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_column;
  logic               last;

  modport source (output valid, mean_value, out_row, out_column, last, input ready);
  modport sink   (input valid, mean_value, out_row, out_column, last, output ready);
endinterface

### sv/bbi_line_store.sv
// Two line memories (upper and middle rows), read-modify-write per byte.
// Depends on bbi_pkg. Forwards the previous cycle's write on an address match.
module bbi_line_store import bbi_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic [PIX_W-1:0] rd_pixel,
  output logic             tap_valid,
  output logic [PIX_W-1:0] tap_up,
  output logic [PIX_W-1:0] tap_mid,
  output logic [PIX_W-1:0] tap_px
);

  logic [PIX_W-1:0] mem_upper [DEPTH];
  logic [PIX_W-1:0] mem_middle [DEPTH];

  logic [PIX_W-1:0] q_up;
  logic [PIX_W-1:0] q_mid;
  logic             v1;
  logic [AW-1:0]    a1;
  logic [PIX_W-1:0] px1;

  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [PIX_W-1:0] fwd_up;
  logic [PIX_W-1:0] fwd_mid;

  logic             hit;

  assign hit     = fwd_valid && (fwd_addr == a1);
  assign tap_up  = hit ? fwd_up : q_up;
  assign tap_mid = hit ? fwd_mid : q_mid;
  assign tap_px  = px1;
  assign tap_valid = v1;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_up <= mem_upper[rd_addr];
    end
    if (v1) begin
      mem_upper[a1] <= tap_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_mid <= mem_middle[rd_addr];
    end
    if (v1) begin
      mem_middle[a1] <= px1;
    end
  end

  always_ff @(posedge clk) begin
    a1      <= rd_addr;
    px1     <= rd_pixel;
    fwd_addr <= a1;
    fwd_up   <= tap_mid;
    fwd_mid  <= px1;
    if (rst) begin
      v1        <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      v1        <= rd_en;
      fwd_valid <= v1;
    end
  end

endmodule

### sv/bbi_window.sv
// 3-row window taps, nine-byte sum and divide by nine by reciprocal.
// Depends on bbi_pkg. The sum is registered after the taps.
module bbi_window import bbi_pkg::*; #(
  parameter int STRIDE = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             tap_valid,
  input  logic [PIX_W-1:0] tap_up,
  input  logic [PIX_W-1:0] tap_mid,
  input  logic [PIX_W-1:0] tap_px,
  input  logic             emit1,
  input  meta_t            meta1,
  output logic             res_valid,
  output result_t          res
);

  localparam int WIN = 2 * STRIDE + 1;

  logic [PIX_W-1:0] taps [3][WIN];

  logic             v2;
  meta_t            meta2;
  logic             v3;
  meta_t            meta3;
  logic [SUM_W-1:0] sum3;
  logic [SUM_W-1:0] sum_next;
  logic [PROD_W-1:0] prod;

  always_comb begin
    sum_next = '0;
    for (int k = 0; k < 3; k++) begin
      sum_next = sum_next + SUM_W'(taps[k][0]) + SUM_W'(taps[k][STRIDE])
               + SUM_W'(taps[k][2*STRIDE]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < WIN; j++) begin
          taps[k][j] <= '0;
        end
      end
    end else if (tap_valid) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < WIN - 1; j++) begin
          taps[k][j] <= taps[k][j+1];
        end
      end
      taps[0][WIN-1] <= tap_up;
      taps[1][WIN-1] <= tap_mid;
      taps[2][WIN-1] <= tap_px;
    end
  end

  always_ff @(posedge clk) begin
    meta2 <= meta1;
    meta3 <= meta2;
    sum3  <= sum_next;
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= tap_valid && emit1;
      v3 <= v2;
    end
  end

  assign prod       = PROD_W'(sum3) * PROD_W'(RECIP_9);
  assign res_valid  = v3;
  assign res.mean   = prod[RECIP_SHIFT +: PIX_W];
  assign res.last   = meta3.last;
  assign res.row    = meta3.row;
  assign res.column = meta3.column;

endmodule

### sv/bbi_out_fifo.sv
// Result queue in front of the output channel; space is reserved upstream.
// Depends on bbi_pkg.
module bbi_out_fifo import bbi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  result_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end
  end

endmodule

### sv/box_blur_3x3_interleaved.sv
// 3x3 same-channel box blur over an interleaved raster byte stream.
// Channels: pixels (sink) takes one byte per beat with frame_start on the
// first byte of a frame; results (source) gives mean_value, out_row,
// out_column and last. A beat on pixels is taken when valid and ready are
// high; bytes on the frame border give no result beat.
// Configuration: cfg_write with cfg_index 0 (line_bytes) or 1 (row_count) and
// cfg_data; the user must write them only while the block is idle (no check).
// Throughput: one byte per cycle while ready is high. Each byte does one read
// and one write of each line memory (one read port, one write port each); the
// write lands in the cycle after the read; a same-address read is forwarded.
// Pipeline: the byte that completes a window passes memory read, window shift,
// sum and reciprocal multiply into the result queue before its result beat
// is available.
// Stall: an 8-entry result queue absorbs results; ready drops only when the
// queue plus results in flight fill it, so the pipeline never stops.
// Reset (rst, synchronous): positions, window and queue clear, registers
// return to 1920 bytes per row and 480 rows; line memory contents are kept
// and no clearing pass is run.
module box_blur_3x3_interleaved import bbi_pkg::*; #(
  parameter int MAX_LINE_BYTES = 4096,
  parameter int CHANNEL_STRIDE = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bbi_in_if.sink               pixels,
  bbi_out_if.source            results
);

  localparam int AW = $clog2(MAX_LINE_BYTES);
  localparam int LW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

  logic [CFG_W-1:0]   line_bytes;
  logic [CFG_W-1:0]   row_count;
  logic [AW-1:0]      column_position;
  logic [COORD_W-1:0] row_position;
  logic [FIFO_AW:0]   occupancy;

  logic [LW-1:0]      lb_raw;
  logic [LW-1:0]      lb;
  logic [CFG_W-1:0]   rc;
  logic               accept;
  logic [AW-1:0]      c_cur;
  logic [COORD_W-1:0] r_cur;
  logic [LW-1:0]      c_ext;
  logic [CFG_W-1:0]   r_ext;
  logic [LW-1:0]      c_inc;
  logic [CFG_W-1:0]   r_inc;
  logic               emit;
  meta_t              meta;
  logic               emit1;
  meta_t              meta1;

  logic               tap_valid;
  logic [PIX_W-1:0]   tap_up;
  logic [PIX_W-1:0]   tap_mid;
  logic [PIX_W-1:0]   tap_px;
  logic               res_valid;
  result_t            res;
  logic               pop;
  logic               q_not_empty;
  result_t            q_head;

  assign lb_raw = LW'(line_bytes);
  assign lb = (lb_raw == '0) ? LW'(1) :
              (lb_raw > LW'(MAX_LINE_BYTES)) ? LW'(MAX_LINE_BYTES) : lb_raw;
  assign rc = (row_count == '0) ? CFG_W'(1) :
              (row_count > MAX_ROWS) ? MAX_ROWS : row_count;

  assign pixels.ready = (occupancy < (FIFO_AW+1)'(FIFO_DEPTH));
  assign accept       = pixels.valid && pixels.ready;

  assign c_cur = pixels.frame_start ? '0 : column_position;
  assign r_cur = pixels.frame_start ? '0 : row_position;
  assign c_ext = LW'(c_cur);
  assign r_ext = CFG_W'(r_cur);
  assign c_inc = c_ext + LW'(1);
  assign r_inc = r_ext + CFG_W'(1);

  assign emit = (r_ext >= CFG_W'(2)) && (r_inc <= rc) && (c_ext < lb)
             && (c_ext >= LW'(2 * CHANNEL_STRIDE));
  assign meta.last   = (r_inc == rc) && (c_inc == lb);
  assign meta.row    = r_cur - COORD_W'(1);
  assign meta.column = COORD_W'(c_ext - LW'(CHANNEL_STRIDE));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_bytes <= LINE_BYTES_RST;
      row_count  <= ROW_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LINE_BYTES: line_bytes <= cfg_data;
        REG_ROW_COUNT:  row_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    meta1 <= meta;
    emit1 <= emit;
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      occupancy       <= '0;
    end else begin
      if (accept) begin
        if (c_inc >= lb) begin
          column_position <= '0;
          row_position    <= (r_inc >= rc) ? '0 : r_inc[COORD_W-1:0];
        end else begin
          column_position <= c_inc[AW-1:0];
          row_position    <= r_cur;
        end
      end
      occupancy <= occupancy + (FIFO_AW+1)'(accept && emit) - (FIFO_AW+1)'(pop);
    end
  end

  bbi_line_store #(
    .DEPTH (MAX_LINE_BYTES),
    .AW    (AW)
  ) u_line_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr   (c_cur),
    .rd_pixel  (pixels.pixel_byte),
    .tap_valid (tap_valid),
    .tap_up    (tap_up),
    .tap_mid   (tap_mid),
    .tap_px    (tap_px)
  );

  bbi_window #(
    .STRIDE (CHANNEL_STRIDE)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .tap_valid (tap_valid),
    .tap_up    (tap_up),
    .tap_mid   (tap_mid),
    .tap_px    (tap_px),
    .emit1     (emit1),
    .meta1     (meta1),
    .res_valid (res_valid),
    .res       (res)
  );

  assign pop = q_not_empty && results.ready;

  bbi_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  assign results.valid      = q_not_empty;
  assign results.mean_value = q_head.mean;
  assign results.out_row    = q_head.row;
  assign results.out_column = q_head.column;
  assign results.last       = q_head.last;

endmodule

### sv/bbi_checker.sv
// Port-level checks of the box blur, bound to the top level.
// Depends on bbi_pkg; sees only the top level's ports.
module bbi_checker import bbi_pkg::*; #(
  parameter int CHANNEL_STRIDE = 3
) (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIX_W-1:0]   out_mean,
  input logic [COORD_W-1:0] out_row,
  input logic [COORD_W-1:0] out_column,
  input logic               out_last
);

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_ready_after_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_mean) && $stable(out_row)
      && $stable(out_column) && $stable(out_last))
    else $error("stalled result beat changed");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_row != '0 && out_column >= COORD_W'(CHANNEL_STRIDE))
    else $error("result beat for a border byte");

endmodule

bind box_blur_3x3_interleaved bbi_checker #(
  .CHANNEL_STRIDE (CHANNEL_STRIDE)
) u_bbi_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (pixels.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_mean   (results.mean_value),
  .out_row    (results.out_row),
  .out_column (results.out_column),
  .out_last   (results.last)
);

### sim/tb_box_blur_3x3_interleaved.sv
`timescale 1ns / 1ps
// Self-checking bench for box_blur_3x3_interleaved: queued byte driver, result monitor,
// and a byte-level model of the line stores and window. Uses bbi_pkg, bbi_in_if, bbi_out_if.
module tb_box_blur_3x3_interleaved;
  import bbi_pkg::*;

  localparam int LINE_DEPTH   = 4096;
  localparam int ROW_LIMIT    = 4096;
  localparam int LANE_STRIDE  = 3;
  localparam int WIN_W        = 2 * LANE_STRIDE + 1;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int REPORT_CAP   = 100;
  localparam int IDLE_PCT     = 9;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fs;
  } pixel_beat_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bbi_in_if  pix_if ();
  bbi_out_if res_if ();

  box_blur_3x3_interleaved i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_if.sink),
    .results   (res_if.source)
  );

  pixel_beat_t beat_q[$];
  result_t     expected_blurs[$];
  pixel_beat_t next_beat;
  result_t     oldest_blur;

  // model state
  logic [CFG_W-1:0]   line_bytes_reg;
  logic [CFG_W-1:0]   row_count_reg;
  logic [PIX_W-1:0]   upper_line [LINE_DEPTH];
  logic [PIX_W-1:0]   middle_line [LINE_DEPTH];
  logic [PIX_W-1:0]   taps [3][WIN_W];
  logic [COORD_W-1:0] row_pos;
  logic [COORD_W-1:0] col_pos;

  logic calm_run;
  logic hold_req;
  logic hold_done;
  int   hold_left;
  int   cycle_count;
  int   errors;
  int   beats_in;
  int   results_checked;
  int   settings_written;
  int   input_stall_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic predict_blur(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned lb;
    int unsigned rc;
    int unsigned r;
    int unsigned c;
    int unsigned sum;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    result_t blur;
    lb = line_bytes_reg;
    rc = row_count_reg;
    if (lb < 1) lb = 1;
    if (lb > LINE_DEPTH) lb = LINE_DEPTH;
    if (rc < 1) rc = 1;
    if (rc > ROW_LIMIT) rc = ROW_LIMIT;
    if (fs) begin
      row_pos = '0;
      col_pos = '0;
    end
    r = row_pos;
    c = col_pos;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = px;
    for (int k = 0; k < WIN_W - 1; k++) begin
      for (int j = 0; j < 3; j++) taps[j][k] = taps[j][k+1];
    end
    taps[0][WIN_W-1] = up;
    taps[1][WIN_W-1] = mid;
    taps[2][WIN_W-1] = px;
    if (r >= 2 && r + 1 <= rc && c < lb && c >= 2 * LANE_STRIDE) begin
      sum = 0;
      for (int j = 0; j < 3; j++)
        sum += taps[j][0] + taps[j][LANE_STRIDE] + taps[j][2*LANE_STRIDE];
      blur.mean   = PIX_W'(sum / 9);
      blur.row    = COORD_W'(r - 1);
      blur.column = COORD_W'(c - LANE_STRIDE);
      blur.last   = (r + 1 == rc) && (c + 1 == lb);
      expected_blurs.push_back(blur);
    end
    c++;
    if (c >= lb) begin
      c = 0;
      r++;
      if (r >= rc) r = 0;
    end
    col_pos = COORD_W'(c);
    row_pos = COORD_W'(r);
  endtask

  task automatic report_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (beat_q.size() != 0 && (calm_run || $urandom_range(99) >= IDLE_PCT)) begin
        next_beat = beat_q.pop_front();
        pix_if.valid       <= 1'b1;
        pix_if.pixel_byte  <= next_beat.pix;
        pix_if.frame_start <= next_beat.fs;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // accepted bytes feed the model
  always @(posedge clk) begin
    if (!rst && pix_if.valid) begin
      if (pix_if.ready) begin
        predict_blur(pix_if.pixel_byte, pix_if.frame_start);
        beats_in++;
      end else begin
        input_stall_cycles++;
      end
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      res_if.ready <= 1'b0;
      hold_left    <= 150;
      hold_done    <= 1'b1;
    end else begin
      res_if.ready <= calm_run || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_blurs.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result beat with none expected: expected nothing, actual mean %0d row %0d col %0d",
                   $time, res_if.mean_value, res_if.out_row, res_if.out_column);
      end else begin
        oldest_blur = expected_blurs.pop_front();
        report_field("mean_value", oldest_blur.mean, res_if.mean_value);
        report_field("out_row", oldest_blur.row, res_if.out_row);
        report_field("out_column", oldest_blur.column, res_if.out_column);
        report_field("last", oldest_blur.last, res_if.last);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_blurs.size());
      $display("** box_blur_3x3_interleaved: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (beat_q.size() != 0 || pix_if.valid || expected_blurs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_LINE_BYTES) line_bytes_reg = val;
    else row_count_reg = val;
    settings_written++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input int lb, input int rc);
    write_reg(REG_LINE_BYTES, CFG_W'(lb));
    write_reg(REG_ROW_COUNT, CFG_W'(rc));
  endtask

  // fill < 0 gives random bytes
  task automatic push_bytes(input int count, input logic fs_first, input int fill);
    pixel_beat_t b;
    for (int i = 0; i < count; i++) begin
      b.pix = (fill < 0) ? PIX_W'($urandom_range(255)) : PIX_W'(fill);
      b.fs  = fs_first && (i == 0);
      beat_q.push_back(b);
    end
  endtask

  // mostly whole frames; some cut short, some running on without a frame mark
  task automatic push_frames(input int lb, input int rc, input int budget);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < budget) begin
      pick = (sent == 0) ? 0 : $urandom_range(99);
      if (pick < 75) begin
        len = lb * rc;
        push_bytes(len, 1'b1, -1);
      end else if (pick < 90) begin
        len = $urandom_range(1, lb * rc);
        push_bytes(len, 1'b1, -1);
      end else begin
        len = $urandom_range(1, 2 * lb);
        push_bytes(len, 1'b0, -1);
      end
      sent += len;
    end
  endtask

  initial begin
    int lbv;
    int rcv;
    rst                = 1'b1;
    cfg_write          = 1'b0;
    cfg_index          = REG_LINE_BYTES;
    cfg_data           = '0;
    pix_if.valid       = 1'b0;
    pix_if.pixel_byte  = '0;
    pix_if.frame_start = 1'b0;
    res_if.ready       = 1'b0;
    calm_run           = 1'b0;
    hold_req           = 1'b0;
    line_bytes_reg     = LINE_BYTES_RST;
    row_count_reg      = ROW_COUNT_RST;
    row_pos            = '0;
    col_pos            = '0;
    for (int j = 0; j < 3; j++)
      for (int k = 0; k < WIN_W; k++) taps[j][k] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, saturated bytes, first row only
    push_bytes(64, 1'b1, 255);
    wait_drained();

    // smallest frame: one result, flagged last; then two frames back to back via wrap
    configure(7, 3);
    push_bytes(21, 1'b1, 0);
    push_bytes(42, 1'b1, -1);
    wait_drained();

    // geometries that give no results, including clamped zeros
    configure(0, 0);
    push_bytes(12, 1'b1, -1);
    wait_drained();
    configure(6, 5);
    push_bytes(35, 1'b1, -1);
    wait_drained();
    configure(7, 2);
    push_bytes(28, 1'b1, -1);
    wait_drained();

    // shrink the geometry mid-frame
    configure(20, 8);
    push_bytes(75, 1'b1, -1);
    wait_drained();
    write_reg(REG_LINE_BYTES, CFG_W'(9));
    write_reg(REG_ROW_COUNT, CFG_W'(6));
    push_bytes(60, 1'b0, -1);
    wait_drained();

    // row count above range clamps to 4096
    configure(7, 8191);
    push_bytes(42, 1'b1, -1);
    wait_drained();

    // random part; long result hold-off first
    configure(9, 12);
    hold_req <= 1'b1;
    push_frames(9, 12, 200);
    wait_drained();

    lbv = $urandom_range(7, 24);
    rcv = $urandom_range(3, 10);
    configure(lbv, rcv);
    calm_run <= 1'b1;
    push_frames(lbv, rcv, 200);
    wait_drained();
    calm_run <= 1'b0;

    lbv = $urandom_range(7, 24);
    rcv = $urandom_range(3, 10);
    configure(lbv, rcv);
    push_frames(lbv, rcv, 100);
    wait_drained();
    push_frames(lbv, rcv, 100);
    wait_drained();

    lbv = $urandom_range(7, 24);
    rcv = $urandom_range(3, 10);
    configure(lbv, rcv);
    push_frames(lbv, rcv, 200);
    wait_drained();

    $display("%0d bytes in, %0d results checked, %0d register writes, %0d cycles of input stall",
             beats_in, results_checked, settings_written, input_stall_cycles);
    $display("covered reset geometry, clamped and degenerate sizes, mid-frame shrink, random frames");
    if (errors == 0) begin
      $display("** box_blur_3x3_interleaved: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** box_blur_3x3_interleaved: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
sv/bbi_pkg.sv
sv/bbi_if.sv
sv/bbi_line_store.sv
sv/bbi_window.sv
sv/bbi_out_fifo.sv
sv/box_blur_3x3_interleaved.sv
sv/bbi_checker.sv
sim/tb_box_blur_3x3_interleaved.sv
